FILE: hdl/deadband_sample_logger_assert.svh
// Assertion macros for the deadband sample logger.
// Included by the top level; needs nothing else.
`ifndef DEADBAND_SAMPLE_LOGGER_ASSERT_SVH
`define DEADBAND_SAMPLE_LOGGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deadband_sample_logger: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deadband_sample_logger: next-cycle check failed");

`endif

FILE: hdl/dsl_pkg.sv
// Shared codes, constants and types of the deadband sample logger.
// No dependencies.
`default_nettype none
package dsl_pkg;
  localparam int CHANNELS_DEF   = 16;
  localparam int RING_DEPTH_DEF = 32;

  localparam logic [1:0] CMD_POLL    = 2'd0;
  localparam logic [1:0] CMD_RECORD  = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_CURRENT = 2'd3;

  localparam logic [2:0] ST_STORED     = 3'd0;
  localparam logic [2:0] ST_NOT_DUE    = 3'd1;
  localparam logic [2:0] ST_SUPPRESSED = 3'd2;
  localparam logic [2:0] ST_READ_FAIL  = 3'd3;
  localparam logic [2:0] ST_NO_CHANNEL = 3'd4;
  localparam logic [2:0] ST_MATCH      = 3'd5;
  localparam logic [2:0] ST_QUERY_END  = 3'd6;
  localparam logic [2:0] ST_CURRENT    = 3'd7;

  localparam logic [2:0] REG_ACTIVE_CHANNELS = 3'd0;
  localparam logic [2:0] REG_CHANNEL_ENABLE  = 3'd1;
  localparam logic [2:0] REG_POLL_INTERVAL   = 3'd2;
  localparam logic [2:0] REG_DEADBAND        = 3'd3;
  localparam logic [2:0] REG_COMPRESS_MODE   = 3'd4;

  localparam logic [1:0] CMP_NONE     = 2'd0;
  localparam logic [1:0] CMP_DEADBAND = 2'd1;
  localparam logic [1:0] CMP_SWING    = 2'd2;

  localparam logic [7:0]  QUAL_GOOD         = 8'd192;
  localparam logic [31:0] POLL_INTERVAL_RST = 32'd1000;
  localparam logic [15:0] CHANNEL_EN_RST    = 16'hFFFF;

  typedef struct packed {
    logic [47:0]        tstamp;
    logic signed [31:0] value;
    logic [7:0]         quality;
  } ring_entry_t;
endpackage
`default_nettype wire

FILE: hdl/dsl_chan_mem.sv
// Per-channel state memory with a registered read.
// Valid bits make unwritten entries read as zero after reset. Uses dsl_pkg.
`default_nettype none
module dsl_chan_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);
  import dsl_pkg::*;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dsl_ring_mem.sv
// Sample ring storage for all channels, one write and one registered read port.
// Uses dsl_pkg for the entry type.
`default_nettype none
module dsl_ring_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire dsl_pkg::ring_entry_t wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output dsl_pkg::ring_entry_t      rd_data
);
  import dsl_pkg::*;

  ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: hdl/deadband_sample_logger.sv
// Deadband sample logger: top level with command sequencer and output register.
// Depends on dsl_pkg, dsl_chan_mem, dsl_ring_mem and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer: poll,
//   record, query window or read current value for one channel.
//   Result channel (out_valid/out_ready) carries the results; out_last_flag
//   marks the final result of each command. A query gives one result per
//   matching sample, oldest first, up to in_max_matches, then an end marker.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
//   write only while the block is idle.
//   A poll, record or current command reads the channel state, evaluates,
//   then writes back and loads its result into the output register.
//   A query reads then compares each ring entry walked through the one ring
//   read port, then loads the end marker. One command is in flight at a time.
//   Reset (synchronous, rst_n low) resets the sequencer, the configuration
//   registers and output valid and clears the channel state valid bits; the
//   ring holds no reset state and needs no clearing pass.
//   Receiver stall: the output register holds the result, the sequencer waits
//   while it has a result to load, and in_ready stays low until the last one is loaded.
`default_nettype none
module deadband_sample_logger #(
  parameter int CHANNELS   = dsl_pkg::CHANNELS_DEF,
  parameter int RING_DEPTH = dsl_pkg::RING_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_channel,
  input  wire logic [47:0] in_time_stamp,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic        in_read_ok,
  input  wire logic        in_sensor_good,
  input  wire logic [7:0]  in_given_quality,
  input  wire logic [47:0] in_window_start,
  input  wire logic [47:0] in_window_end,
  input  wire logic [5:0]  in_max_matches,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [47:0]      out_time,
  output logic signed [31:0] out_value,
  output logic [7:0]       out_quality,
  output logic [31:0]      out_stored_total,
  output logic [31:0]      out_suppressed_total,
  output logic [5:0]       out_buffered,
  output logic             out_last_flag
);
  import dsl_pkg::*;
`include "deadband_sample_logger_assert.svh"

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W  = $clog2(RING_DEPTH);
  localparam int FL_W  = $clog2(RING_DEPTH + 1);
  localparam int SX_W  = FL_W + 1;
  localparam int R_TOT = CHANNELS * RING_DEPTH;
  localparam int AW    = $clog2(R_TOT);

  typedef struct packed {
    logic [SL_W-1:0]    slot;
    logic [FL_W-1:0]    fill;
    logic signed [31:0] kept_value;
    logic [47:0]        kept_time;
    logic [47:0]        poll_time;
    logic [31:0]        kept_cnt;
    logic [31:0]        drop_cnt;
  } chan_rec_t;

  localparam int CR_W = $bits(chan_rec_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_WB   = 3'd2;
  localparam logic [2:0] S_QRD  = 3'd3;
  localparam logic [2:0] S_QEV  = 3'd4;
  localparam logic [2:0] S_QEND = 3'd5;

  // configuration registers
  logic [4:0]  active_r;
  logic [15:0] enable_r;
  logic [31:0] interval_r;
  logic [30:0] deadband_r;
  logic [1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      enable_r   <= CHANNEL_EN_RST;
      interval_r <= POLL_INTERVAL_RST;
      deadband_r <= '0;
      mode_r     <= CMP_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_CHANNELS: active_r   <= cfg_wdata[4:0];
        REG_CHANNEL_ENABLE:  enable_r   <= cfg_wdata[15:0];
        REG_POLL_INTERVAL:   interval_r <= cfg_wdata;
        REG_DEADBAND:        deadband_r <= cfg_wdata[30:0];
        REG_COMPRESS_MODE:   mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and captured command
  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [3:0]  ch_r;
  logic [47:0] ts_r, ws_r, we_r;
  logic signed [31:0] val_r;
  logic        rok_r, good_r, bad_r;
  logic [7:0]  gq_r;
  logic [5:0]  max_r;
  logic [2:0]  st_r, st_nxt;

  // query walk
  logic [SL_W-1:0] ptr_r, ptr_nxt;
  logic [FL_W-1:0] qi_r, qi_nxt, qfill_r, qfill_nxt;
  logic [5:0]      found_r, found_nxt;

  logic in_xfer;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // memories
  chan_rec_t       cq, cw;
  logic [CR_W-1:0] cq_raw;
  logic            c_we;
  logic [CH_W-1:0] ch_idx;
  ring_entry_t     rq, rw;
  logic            r_we, r_re;
  logic [AW-1:0]   r_waddr, r_raddr;

  assign ch_idx = CH_W'(ch_r);
  assign cq     = chan_rec_t'(cq_raw);

  dsl_chan_mem #(.DEPTH(CHANNELS), .AW(CH_W), .DW(CR_W)) u_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (CH_W'(in_channel)),
    .rd_data (cq_raw),
    .wr_en   (c_we),
    .wr_addr (ch_idx),
    .wr_data (CR_W'(cw))
  );

  dsl_ring_mem #(.DEPTH(R_TOT), .AW(AW)) u_ring (
    .clk     (clk),
    .wr_en   (r_we),
    .wr_addr (r_waddr),
    .wr_data (rw),
    .rd_en   (r_re),
    .rd_addr (r_raddr),
    .rd_data (rq)
  );

  assign r_waddr = AW'(AW'(ch_idx) * AW'(RING_DEPTH) + AW'(cq.slot));
  assign r_raddr = AW'(AW'(ch_idx) * AW'(RING_DEPTH) + AW'(ptr_r));

  // output register
  logic        ov_r;
  logic [2:0]  os_r;
  logic [47:0] ot_r;
  logic signed [31:0] oval_r;
  logic [7:0]  oq_r;
  logic [31:0] okc_r, odc_r;
  logic [5:0]  ob_r;
  logic        ol_r;
  logic        out_free, o_load;
  logic [2:0]  o_st;
  logic [47:0] o_t;
  logic signed [31:0] o_v;
  logic [7:0]  o_q;
  logic [31:0] o_kc, o_dc;
  logic [5:0]  o_b;
  logic        o_l;

  assign out_free = !ov_r || out_ready;

  // poll evaluation (S_CALC)
  logic [47:0] since;
  logic signed [32:0] diff;
  logic [32:0] adiff;
  logic        not_due, keep;

  always_comb begin
    since   = ts_r - cq.poll_time;
    not_due = since < {16'd0, interval_r};
    diff    = {val_r[31], val_r} - {cq.kept_value[31], cq.kept_value};
    adiff   = diff[32] ? 33'(-diff) : 33'(diff);
    keep    = ((mode_r == CMP_DEADBAND) || (mode_r == CMP_SWING))
              ? (adiff >= {2'b00, deadband_r}) : 1'b1;
  end

  // query start slot: oldest entry
  logic [SX_W-1:0] qstart_raw;
  logic [SL_W-1:0] qstart;
  always_comb begin
    qstart_raw = SX_W'(cq.slot) + SX_W'(RING_DEPTH) - SX_W'(cq.fill);
    qstart = (qstart_raw >= SX_W'(RING_DEPTH))
             ? SL_W'(qstart_raw - SX_W'(RING_DEPTH)) : SL_W'(qstart_raw);
  end

  logic in_win;
  assign in_win = (rq.tstamp >= ws_r) && (rq.tstamp <= we_r);

  logic [7:0] store_q;
  assign store_q = (cmd_r == CMD_RECORD) ? gq_r : (good_r ? QUAL_GOOD : 8'd0);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ptr_nxt   = ptr_r;
    qi_nxt    = qi_r;
    qfill_nxt = qfill_r;
    found_nxt = found_r;
    c_we      = 1'b0;
    cw        = cq;
    r_we      = 1'b0;
    r_re      = 1'b0;
    rw        = '{tstamp: ts_r, value: val_r, quality: store_q};
    o_load    = 1'b0;
    o_st      = st_r;
    o_t       = '0;
    o_v       = '0;
    o_q       = '0;
    o_kc      = cq.kept_cnt;
    o_dc      = cq.drop_cnt;
    o_b       = 6'(cq.fill);
    o_l       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_WB;
        if (bad_r) begin
          st_nxt = ST_NO_CHANNEL;
        end else begin
          unique case (cmd_r)
            CMD_POLL: begin
              priority if (!enable_r[ch_r])           st_nxt = ST_NOT_DUE;
              else if (not_due)                       st_nxt = ST_NOT_DUE;
              else if (!rok_r)                        st_nxt = ST_READ_FAIL;
              else if (keep || (cq.kept_cnt == '0))   st_nxt = ST_STORED;
              else                                    st_nxt = ST_SUPPRESSED;
            end
            CMD_RECORD:  st_nxt = ST_STORED;
            CMD_CURRENT: st_nxt = ST_CURRENT;
            default: begin
              ptr_nxt   = qstart;
              qi_nxt    = '0;
              qfill_nxt = cq.fill;
              found_nxt = '0;
              state_nxt = S_QRD;
            end
          endcase
        end
      end
      S_WB: begin
        // update the channel record, store a kept sample to the ring, deliver one result
        if (st_r == ST_STORED) begin
          cw.slot = (cq.slot == SL_W'(RING_DEPTH - 1)) ? '0 : cq.slot + 1'b1;
          if (cq.fill < FL_W'(RING_DEPTH)) cw.fill = cq.fill + 1'b1;
          if (cq.kept_cnt != '1) cw.kept_cnt = cq.kept_cnt + 1'b1;
          cw.kept_value = val_r;
          cw.kept_time  = ts_r;
        end
        if (st_r == ST_SUPPRESSED && cq.drop_cnt != '1) begin
          cw.drop_cnt = cq.drop_cnt + 1'b1;
        end
        if (cmd_r == CMD_POLL && (st_r == ST_STORED || st_r == ST_SUPPRESSED)) begin
          cw.poll_time = ts_r;
        end
        o_kc = cw.kept_cnt;
        o_dc = cw.drop_cnt;
        o_b  = 6'(cw.fill);
        if (st_r == ST_STORED) begin
          o_t = ts_r;
          o_v = val_r;
          o_q = store_q;
        end else if (st_r == ST_CURRENT) begin
          o_t = cq.kept_time;
          o_v = cq.kept_value;
          o_q = QUAL_GOOD;
        end else if (st_r == ST_NO_CHANNEL) begin
          o_kc = '0;
          o_dc = '0;
          o_b  = '0;
        end
        if (out_free) begin
          o_load    = 1'b1;
          c_we      = !bad_r;
          r_we      = (st_r == ST_STORED);
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        if ((qi_r < qfill_r) && (found_r < max_r)) begin
          r_re      = 1'b1;
          state_nxt = S_QEV;
        end else begin
          state_nxt = S_QEND;
        end
      end
      S_QEV: begin
        o_st = ST_MATCH;
        o_t  = rq.tstamp;
        o_v  = rq.value;
        o_q  = rq.quality;
        o_l  = 1'b0;
        if (!in_win || out_free) begin
          o_load    = in_win;
          found_nxt = in_win ? found_r + 1'b1 : found_r;
          qi_nxt    = qi_r + 1'b1;
          ptr_nxt   = (ptr_r == SL_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
          state_nxt = S_QRD;
        end
      end
      S_QEND: begin
        o_st = ST_QUERY_END;
        if (out_free) begin
          o_load    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (o_load)         ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_cmd;
      ch_r  <= in_channel;
      ts_r  <= in_time_stamp;
      val_r <= in_sample_value;
      rok_r <= in_read_ok;
      good_r <= in_sensor_good;
      gq_r  <= in_given_quality;
      ws_r  <= in_window_start;
      we_r  <= in_window_end;
      max_r <= in_max_matches;
      bad_r <= ({1'b0, in_channel} >= active_r) || (32'(in_channel) >= 32'(CHANNELS));
    end
    st_r    <= st_nxt;
    ptr_r   <= ptr_nxt;
    qi_r    <= qi_nxt;
    qfill_r <= qfill_nxt;
    found_r <= found_nxt;
    if (o_load) begin
      os_r   <= o_st;
      ot_r   <= o_t;
      oval_r <= o_v;
      oq_r   <= o_q;
      okc_r  <= o_kc;
      odc_r  <= o_dc;
      ob_r   <= o_b;
      ol_r   <= o_l;
    end
  end

  assign out_valid            = ov_r;
  assign out_status           = os_r;
  assign out_time             = ot_r;
  assign out_value            = oval_r;
  assign out_quality          = oq_r;
  assign out_stored_total     = okc_r;
  assign out_suppressed_total = odc_r;
  assign out_buffered         = ob_r;
  assign out_last_flag        = ol_r;

  `DSL_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, state_r == S_CALC)
  `DSL_ASSERT_NOW(a_walk_in_ring, clk, rst_n, state_r == S_QEV, qi_r < qfill_r)
  `DSL_ASSERT_NOW(a_found_bounded, clk, rst_n, state_r == S_QEV || state_r == S_QRD,
                  found_r <= max_r)
endmodule
`default_nettype wire
